// ----- src/mde_pkg.sv -----
// ----------------------------------------------------------------------------
// mde_pkg
// Shared types and codes for the MIPS32 decode/execute unit.
// ----------------------------------------------------------------------------
package mde_pkg;

    localparam logic [5:0] OP_RTYPE   = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIUNS = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIUNS = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MTHI  = 6'h11;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MTLO  = 6'h13;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    localparam logic [4:0] RI_BLTZ   = 5'h00;
    localparam logic [4:0] RI_BGEZ   = 5'h01;
    localparam logic [4:0] RI_BLTZAL = 5'h10;
    localparam logic [4:0] RI_BGEZAL = 5'h11;

    localparam logic [3:0] MK_NONE = 4'd0;
    localparam logic [3:0] MK_LW   = 4'd1;
    localparam logic [3:0] MK_LH   = 4'd2;
    localparam logic [3:0] MK_LHU  = 4'd3;
    localparam logic [3:0] MK_LB   = 4'd4;
    localparam logic [3:0] MK_LBU  = 4'd5;
    localparam logic [3:0] MK_SW   = 4'd6;
    localparam logic [3:0] MK_SH   = 4'd7;
    localparam logic [3:0] MK_SB   = 4'd8;

    localparam logic [4:0] LINK_REG = 5'd31;

    // iterative HI/LO operation
    localparam logic [1:0] MD_MUL  = 2'd0;
    localparam logic [1:0] MD_MULU = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;
    localparam logic [1:0] MD_DIVU = 2'd3;

    typedef struct packed {
        logic       load;     // capture the input transaction
        logic       md_start; // start multiply/divide on captured operands
        logic       md_step;  // one multiply/divide iteration
        logic       md_done;  // write back HI/LO
        logic       out_load; // move the decoded result into the output register
    } t_cmd;

    typedef struct packed {
        logic       is_md;    // captured instruction needs the HI/LO unit
        logic       md_last;  // all iterations done
    } t_status;

    typedef struct packed {
        logic        writes_reg;
        logic [4:0]  dest_reg;
        logic [31:0] result;
        logic        br_flag;
        logic        taken;
        logic [31:0] target;
        logic [3:0]  mem_kind;
        logic [31:0] eff_addr;
        logic [31:0] store_data;
    } t_res;

endpackage

// ----- src/mde_ctrl.sv -----
// ----------------------------------------------------------------------------
// mde_ctrl
// Controller: input capture, multiply/divide sequencing, output handshake.
// ----------------------------------------------------------------------------
module mde_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  mde_pkg::t_status i_status,
    output mde_pkg::t_cmd    o_cmd
);
    import mde_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_DEC     = 2'd1;
    localparam logic [1:0] S_MD      = 2'd2;
    localparam logic [1:0] S_DEC_OUT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    // output register may be refilled as soon as it empties
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.is_md) begin
                    o_cmd.md_start = 1'b1;
                    n_state        = S_MD;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_MD: begin
                o_cmd.md_step = 1'b1;
                if (i_status.md_last) begin
                    o_cmd.md_done = 1'b1;
                    n_state       = S_DEC_OUT;
                end
            end
            S_DEC_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- src/mde_dpath.sv -----
// ----------------------------------------------------------------------------
// mde_dpath
// Datapath: decode, ALU, branch unit, HI/LO and the iterative mul/div unit.
// ----------------------------------------------------------------------------
module mde_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mde_pkg::t_cmd    i_cmd,
    output mde_pkg::t_status o_status,
    input  logic [31:0]      i_instruction,
    input  logic [31:0]      i_pc,
    input  logic [31:0]      i_rs_value,
    input  logic [31:0]      i_rt_value,
    input  logic             i_out_load,
    output mde_pkg::t_res    o_res
);
    import mde_pkg::*;

    logic [31:0] r_ins, r_pc, r_a, r_b;
    logic [31:0] r_hi, r_lo;
    t_res        r_res;

    logic [5:0]  op, fn;
    logic [4:0]  rt, rd, sh;
    logic [15:0] imm;
    logic [31:0] simm, zimm, nxt, btgt;

    assign op   = r_ins[31:26];
    assign rt   = r_ins[20:16];
    assign rd   = r_ins[15:11];
    assign sh   = r_ins[10:6];
    assign fn   = r_ins[5:0];
    assign imm  = r_ins[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign zimm = {16'd0, imm};
    assign nxt  = r_pc + 32'd4;
    assign btgt = nxt + {simm[29:0], 2'b00};

    // ---------------- mul/div: one bit per cycle ----------------
    logic [1:0]  r_md_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_acc;      // mul: {hi,lo} product; div: {rem, quotient}
    logic [31:0] r_opb;      // multiplicand / divisor magnitude
    logic        r_neg_q, r_neg_r, r_zero;
    logic        md_signed;
    logic [31:0] mag_a, mag_b;
    logic [32:0] trial;
    logic [32:0] madd;
    logic [63:0] md_next;
    logic [63:0] mul_fix;
    logic [31:0] q_fin, r_fin;

    assign md_signed = (fn == FN_MULT) || (fn == FN_DIV);
    assign mag_a = (md_signed && r_a[31]) ? (32'd0 - r_a) : r_a;
    assign mag_b = (md_signed && r_b[31]) ? (32'd0 - r_b) : r_b;

    always_comb begin
        madd  = {1'b0, r_acc[63:32]} + (r_acc[0] ? {1'b0, r_opb} : 33'd0);
        trial = {r_acc[63:32], r_acc[31]} - {1'b0, r_opb};
        if (r_md_op == MD_MUL || r_md_op == MD_MULU) begin
            md_next = {madd, r_acc[31:1]};
        end else if (!trial[32]) begin
            md_next = {trial[31:0], r_acc[30:0], 1'b1};
        end else begin
            md_next = {r_acc[62:0], 1'b0};
        end
        mul_fix = r_neg_q ? (64'd0 - r_acc) : r_acc;
        q_fin   = r_neg_q ? (32'd0 - r_acc[31:0]) : r_acc[31:0];
        r_fin   = r_neg_r ? (32'd0 - r_acc[63:32]) : r_acc[63:32];
    end

    assign o_status.is_md   = (op == OP_RTYPE) &&
                              (fn == FN_MULT || fn == FN_MULTU ||
                               fn == FN_DIV || fn == FN_DIVU);
    assign o_status.md_last = (r_cnt == 6'd32);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ins <= i_instruction;
            r_pc  <= i_pc;
            r_a   <= i_rs_value;
            r_b   <= i_rt_value;
        end
        if (i_cmd.md_start) begin
            r_md_op <= fn[1:0];
            r_cnt   <= 6'd0;
            r_acc   <= {32'd0, mag_a};
            r_opb   <= mag_b;
            r_neg_q <= md_signed && (r_a[31] ^ r_b[31]);
            r_neg_r <= md_signed && r_a[31];
            r_zero  <= (r_b == 32'd0);
        end else if (i_cmd.md_step && !o_status.md_last) begin
            r_acc <= md_next;
            r_cnt <= r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_cmd.md_done) begin
            if (r_md_op == MD_MUL || r_md_op == MD_MULU) begin
                r_hi <= mul_fix[63:32];
                r_lo <= mul_fix[31:0];
            end else if (r_zero) begin
                r_hi <= '0;
                r_lo <= '0;
            end else begin
                r_hi <= r_fin;
                r_lo <= q_fin;
            end
        end else if (i_out_load && op == OP_RTYPE && fn == FN_MTHI) begin
            r_hi <= r_a;
        end else if (i_out_load && op == OP_RTYPE && fn == FN_MTLO) begin
            r_lo <= r_a;
        end
    end

    // ---------------- decode and execute ----------------
    t_res        d;
    logic        wr, neg;
    logic [4:0]  dst;

    always_comb begin
        d        = '0;
        d.target = nxt;
        wr       = 1'b0;
        dst      = 5'd0;
        neg      = r_a[31];
        case (op)
            OP_RTYPE: begin
                wr  = 1'b1;
                dst = rd;
                case (fn)
                    FN_SLL:  d.result = r_b << sh;
                    FN_SRL:  d.result = r_b >> sh;
                    FN_SRA:  d.result = $signed(r_b) >>> sh;
                    FN_SLLV: d.result = r_b << r_a[4:0];
                    FN_SRLV: d.result = r_b >> r_a[4:0];
                    FN_SRAV: d.result = $signed(r_b) >>> r_a[4:0];
                    FN_JR: begin
                        wr = 1'b0; d.br_flag = 1'b1; d.taken = 1'b1;
                        d.target = r_a;
                    end
                    FN_JALR: begin
                        d.result = nxt; d.br_flag = 1'b1; d.taken = 1'b1;
                        d.target = r_a;
                    end
                    FN_MFHI: d.result = r_hi;
                    FN_MFLO: d.result = r_lo;
                    FN_ADD, FN_ADDU: d.result = r_a + r_b;
                    FN_SUB, FN_SUBU: d.result = r_a - r_b;
                    FN_AND:  d.result = r_a & r_b;
                    FN_OR:   d.result = r_a | r_b;
                    FN_XOR:  d.result = r_a ^ r_b;
                    FN_NOR:  d.result = ~(r_a | r_b);
                    FN_SLT:  d.result = {31'd0, $signed(r_a) < $signed(r_b)};
                    FN_SLTU: d.result = {31'd0, r_a < r_b};
                    default: wr = 1'b0;
                endcase
                if (!wr) begin
                    dst      = 5'd0;
                    d.result = '0;
                end
            end
            OP_REGIMM: begin
                case (rt)
                    RI_BLTZ: begin d.br_flag = 1'b1; d.taken = neg; end
                    RI_BGEZ: begin d.br_flag = 1'b1; d.taken = !neg; end
                    RI_BLTZAL: begin
                        d.br_flag = 1'b1; d.taken = neg;
                        wr = 1'b1; dst = LINK_REG; d.result = nxt;
                    end
                    RI_BGEZAL: begin
                        d.br_flag = 1'b1; d.taken = !neg;
                        wr = 1'b1; dst = LINK_REG; d.result = nxt;
                    end
                    default: ;
                endcase
                if (d.taken) d.target = btgt;
            end
            OP_J, OP_JAL: begin
                d.br_flag   = 1'b1;
                d.taken     = 1'b1;
                d.target    = {nxt[31:28], r_ins[25:0], 2'b00};
                if (op == OP_JAL) begin
                    wr = 1'b1; dst = LINK_REG; d.result = nxt;
                end
            end
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
                d.br_flag = 1'b1;
                case (op)
                    OP_BEQ:  d.taken = (r_a == r_b);
                    OP_BNE:  d.taken = (r_a != r_b);
                    OP_BLEZ: d.taken = neg || (r_a == 32'd0);
                    default: d.taken = !neg && (r_a != 32'd0);
                endcase
                if (d.taken) d.target = btgt;
            end
            OP_ADDI, OP_ADDIUNS, OP_SLTI, OP_SLTIUNS,
            OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
                wr  = 1'b1;
                dst = rt;
                case (op)
                    OP_ADDI, OP_ADDIUNS: d.result = r_a + simm;
                    OP_SLTI:  d.result = {31'd0, $signed(r_a) < $signed(simm)};
                    OP_SLTIUNS: d.result = {31'd0, r_a < simm};
                    OP_ANDI:  d.result = r_a & zimm;
                    OP_ORI:   d.result = r_a | zimm;
                    OP_XORI:  d.result = r_a ^ zimm;
                    default:  d.result = {imm, 16'd0};
                endcase
            end
            default: begin
                case (op)
                    OP_LW:   d.mem_kind = MK_LW;
                    OP_LH:   d.mem_kind = MK_LH;
                    OP_LHU:  d.mem_kind = MK_LHU;
                    OP_LB:   d.mem_kind = MK_LB;
                    OP_LBU:  d.mem_kind = MK_LBU;
                    OP_SW:   d.mem_kind = MK_SW;
                    OP_SH:   d.mem_kind = MK_SH;
                    OP_SB:   d.mem_kind = MK_SB;
                    default: d.mem_kind = MK_NONE;
                endcase
                if (d.mem_kind != MK_NONE) begin
                    d.eff_addr = r_a + simm;
                    if (d.mem_kind <= MK_LBU) begin
                        wr = 1'b1; dst = rt;
                    end else begin
                        d.store_data = r_b;
                    end
                end
            end
        endcase
        d.dest_reg   = dst;
        d.writes_reg = wr && (dst != 5'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_out_load) r_res <= d;
    end

    assign o_res = r_res;

endmodule

// ----- src/mips32_decode_execute.sv -----
// ----------------------------------------------------------------------------
// mips32_decode_execute
// MIPS32 integer decode/execute unit with HI/LO and iterative mul/div.
// ----------------------------------------------------------------------------
// One instruction is taken at a time. An ordinary instruction is decoded in
// the cycle after acceptance and its result is loaded into the output
// register once that is free; the next instruction can be accepted in the
// following cycle. MULT/MULTU/DIV/DIVU go through start, the 32 iterations
// of the shared one-bit-per-cycle multiply/divide unit, HI/LO write-back
// and output load before their result is valid. The output register holds
// a result until the downstream side takes it; while it is full the
// following instruction waits in decode, or a mul/div after HI/LO write-back.
module mips32_decode_execute (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] instruction, [63:32] pc, [95:64] rs_value, [127:96] rt_value
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] writes_reg, [5:1] dest_reg, [37:6] result, [38] branch flag,
    // [39] taken, [71:40] target, [75:72] mem_kind, [107:76] effective address,
    // [139:108] store_data, [143:140] zero
    output logic [143:0] m_axis_tdata
);
    import mde_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_res    res;
    logic    out_valid;

    mde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (out_valid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mde_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_instruction (s_axis_tdata[31:0]),
        .i_pc          (s_axis_tdata[63:32]),
        .i_rs_value    (s_axis_tdata[95:64]),
        .i_rt_value    (s_axis_tdata[127:96]),
        .i_out_load    (cmd.out_load),
        .o_res         (res)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {4'd0, res.store_data, res.eff_addr, res.mem_kind,
                            res.target, res.taken, res.br_flag, res.result,
                            res.dest_reg, res.writes_reg};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !cmd.md_step)
        else $error("mul/div running while idle");
`endif

endmodule

// ----- tb/mips32_decode_execute_test.sv -----
// ----------------------------------------------------------------------------
// mips32_decode_execute_test
// Self-checking bench for the MIPS32 decode/execute unit: a directed table of
// instructions, then random instruction streams biased towards real opcodes,
// checked against an in-bench model of the decoder with its own HI/LO.
// ----------------------------------------------------------------------------
module mips32_decode_execute_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mde_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 500;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;

    mips32_decode_execute dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        logic [31:0] instr;
        logic [31:0] pc;
        logic [31:0] rs_val;
        logic [31:0] rt_val;
    } t_instr_txn;

    typedef struct {
        t_instr_txn txn;
        logic       known;   // expected result typed in
        t_res       res;
    } t_dir_row;

    t_res        exec_queue[$];
    logic [31:0] model_hi = '0;
    logic [31:0] model_lo = '0;
    int          err_count = 0;
    int          rx_count = 0;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;
    bit          sink_done = 1'b0;

    function automatic t_res mk_res(logic wr, logic [4:0] dst, logic [31:0] r,
                                    logic br, logic tk, logic [31:0] tgt,
                                    logic [3:0] mk, logic [31:0] ma,
                                    logic [31:0] sd);
        t_res o;
        o = '{wr, dst, r, br, tk, tgt, mk, ma, sd};
        return o;
    endfunction

    function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // decode and execute one instruction; updates the bench copy of HI/LO
    function automatic t_res execute_instr(t_instr_txn t);
        logic [5:0]  op, fn;
        logic [4:0]  rt, rd, sh;
        logic [15:0] imm;
        logic [31:0] simm, nxt, btgt, a, b;
        logic [63:0] prod;
        logic [31:0] ma, mb, q, r;
        t_res        o;
        a = t.rs_val;
        b = t.rt_val;
        op = t.instr[31:26];
        rt = t.instr[20:16];
        rd = t.instr[15:11];
        sh = t.instr[10:6];
        fn = t.instr[5:0];
        imm = t.instr[15:0];
        simm = {{16{imm[15]}}, imm};
        nxt = t.pc + 32'd4;
        btgt = nxt + (simm << 2);
        o = mk_res(1'b0, '0, '0, 1'b0, 1'b0, nxt, MK_NONE, '0, '0);
        if (op == OP_RTYPE) begin
            o.writes_reg = 1'b1;
            o.dest_reg = rd;
            case (fn)
                FN_SLL:  o.result = b << sh;
                FN_SRL:  o.result = b >> sh;
                FN_SRA:  o.result = $signed(b) >>> sh;
                FN_SLLV: o.result = b << a[4:0];
                FN_SRLV: o.result = b >> a[4:0];
                FN_SRAV: o.result = $signed(b) >>> a[4:0];
                FN_JR: begin
                    o.writes_reg = 1'b0; o.br_flag = 1'b1; o.taken = 1'b1; o.target = a;
                end
                FN_JALR: begin
                    o.result = nxt; o.br_flag = 1'b1; o.taken = 1'b1; o.target = a;
                end
                FN_MFHI: o.result = model_hi;
                FN_MTHI: begin o.writes_reg = 1'b0; model_hi = a; end
                FN_MFLO: o.result = model_lo;
                FN_MTLO: begin o.writes_reg = 1'b0; model_lo = a; end
                FN_MULT: begin
                    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    {model_hi, model_lo} = prod;
                    o.writes_reg = 1'b0;
                end
                FN_MULTU: begin
                    prod = {32'd0, a} * {32'd0, b};
                    {model_hi, model_lo} = prod;
                    o.writes_reg = 1'b0;
                end
                FN_DIV: begin
                    if (b == '0) begin
                        model_hi = '0; model_lo = '0;
                    end else begin
                        // magnitudes, then fix signs; most-negative / -1 wraps
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        r = ma % mb;
                        model_lo = (a[31] ^ b[31]) ? -q : q;
                        model_hi = a[31] ? -r : r;
                    end
                    o.writes_reg = 1'b0;
                end
                FN_DIVU: begin
                    if (b == '0) begin
                        model_hi = '0; model_lo = '0;
                    end else begin
                        model_hi = a % b; model_lo = a / b;
                    end
                    o.writes_reg = 1'b0;
                end
                FN_ADD, FN_ADDU: o.result = a + b;
                FN_SUB, FN_SUBU: o.result = a - b;
                FN_AND:  o.result = a & b;
                FN_OR:   o.result = a | b;
                FN_XOR:  o.result = a ^ b;
                FN_NOR:  o.result = ~(a | b);
                FN_SLT:  o.result = {31'd0, signed_lt(a, b)};
                FN_SLTU: o.result = {31'd0, a < b};
                default: o.writes_reg = 1'b0;
            endcase
            if (!o.writes_reg) begin
                o.dest_reg = '0; o.result = '0;
            end
        end else if (op == OP_REGIMM) begin
            case (rt)
                RI_BLTZ: begin o.br_flag = 1'b1; o.taken = a[31]; end
                RI_BGEZ: begin o.br_flag = 1'b1; o.taken = !a[31]; end
                RI_BLTZAL: begin
                    o.br_flag = 1'b1; o.taken = a[31];
                    o.writes_reg = 1'b1; o.dest_reg = LINK_REG; o.result = nxt;
                end
                RI_BGEZAL: begin
                    o.br_flag = 1'b1; o.taken = !a[31];
                    o.writes_reg = 1'b1; o.dest_reg = LINK_REG; o.result = nxt;
                end
                default: ;
            endcase
            if (o.taken) o.target = btgt;
        end else if (op == OP_J || op == OP_JAL) begin
            o.br_flag = 1'b1;
            o.taken = 1'b1;
            o.target = {nxt[31:28], t.instr[25:0], 2'b00};
            if (op == OP_JAL) begin
                o.writes_reg = 1'b1; o.dest_reg = LINK_REG; o.result = nxt;
            end
        end else if (op >= OP_BEQ && op <= OP_BGTZ) begin
            o.br_flag = 1'b1;
            case (op)
                OP_BEQ:  o.taken = (a == b);
                OP_BNE:  o.taken = (a != b);
                OP_BLEZ: o.taken = a[31] || a == '0;
                default: o.taken = !a[31] && a != '0;
            endcase
            if (o.taken) o.target = btgt;
        end else if (op >= OP_ADDI && op <= OP_LUI) begin
            o.writes_reg = 1'b1;
            o.dest_reg = rt;
            case (op)
                OP_ADDI, OP_ADDIUNS: o.result = a + simm;
                OP_SLTI:  o.result = {31'd0, signed_lt(a, simm)};
                OP_SLTIUNS: o.result = {31'd0, a < simm};
                OP_ANDI:  o.result = a & {16'd0, imm};
                OP_ORI:   o.result = a | {16'd0, imm};
                OP_XORI:  o.result = a ^ {16'd0, imm};
                default:  o.result = {imm, 16'd0};
            endcase
        end else begin
            case (op)
                OP_LW:  o.mem_kind = MK_LW;
                OP_LH:  o.mem_kind = MK_LH;
                OP_LHU: o.mem_kind = MK_LHU;
                OP_LB:  o.mem_kind = MK_LB;
                OP_LBU: o.mem_kind = MK_LBU;
                OP_SW:  o.mem_kind = MK_SW;
                OP_SH:  o.mem_kind = MK_SH;
                OP_SB:  o.mem_kind = MK_SB;
                default: ;
            endcase
            if (o.mem_kind != MK_NONE) begin
                o.eff_addr = a + simm;
                if (o.mem_kind <= MK_LBU) begin
                    o.writes_reg = 1'b1; o.dest_reg = rt;
                end else begin
                    o.store_data = b;
                end
            end
        end
        if (o.dest_reg == '0) o.writes_reg = 1'b0;
        return o;
    endfunction

    function automatic logic [31:0] r_type(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [4:0] sh, logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        $display("mismatch on result %0d: %s got %h expected %h", rx_count, what, got, want);
    endtask

    // random instruction, mostly legal encodings with random fields
    function automatic logic [31:0] random_instr();
        logic [5:0] ops[24];
        logic [5:0] fns[26];
        logic [4:0] ris[4];
        logic [31:0] w;
        int sel;
        ops = '{OP_RTYPE, OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
                OP_ADDI, OP_ADDIUNS, OP_SLTI, OP_SLTIUNS, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW};
        fns = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
                FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
                FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
                FN_SLT, FN_SLTU};
        ris = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL};
        w = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            w[31:26] = OP_RTYPE;
            w[5:0] = fns[$urandom_range(0, 25)];
        end else if (sel < 42) begin
            w[31:26] = OP_REGIMM;
            w[20:16] = ris[$urandom_range(0, 3)];
        end else if (sel < 92) begin
            w[31:26] = ops[$urandom_range(2, 23)];
        end
        // remainder: raw noise, mostly unknown encodings
        return w;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_instr(t_instr_txn t);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= {t.rt_val, t.rs_val, t.pc, t.instr};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        exec_queue.push_back(execute_instr(t));
        @(negedge i_clk);
    endtask

    // result side: random back-pressure bursts, checked at the rising edge
    initial begin
        int stall;
        while (!sink_done) begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 14);
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.writes_reg = m_axis_tdata[0];
            got.dest_reg   = m_axis_tdata[5:1];
            got.result     = m_axis_tdata[37:6];
            got.br_flag    = m_axis_tdata[38];
            got.taken      = m_axis_tdata[39];
            got.target     = m_axis_tdata[71:40];
            got.mem_kind   = m_axis_tdata[75:72];
            got.eff_addr   = m_axis_tdata[107:76];
            got.store_data = m_axis_tdata[139:108];
            rx_count++;
            if (exec_queue.size() == 0) begin
                err_count++;
                $display("unexpected result transaction %0d", rx_count);
            end else begin
                want = exec_queue.pop_front();
                if (got.writes_reg !== want.writes_reg)
                    report_mismatch("writes_reg", 32'(got.writes_reg),
                                    32'(want.writes_reg));
                if (got.dest_reg !== want.dest_reg)
                    report_mismatch("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
                if (got.result !== want.result)
                    report_mismatch("result", got.result, want.result);
                if (got.br_flag !== want.br_flag)
                    report_mismatch("branch flag", 32'(got.br_flag), 32'(want.br_flag));
                if (got.taken !== want.taken)
                    report_mismatch("taken", 32'(got.taken), 32'(want.taken));
                if (got.target !== want.target)
                    report_mismatch("target", got.target, want.target);
                if (got.mem_kind !== want.mem_kind)
                    report_mismatch("mem_kind", 32'(got.mem_kind), 32'(want.mem_kind));
                if (got.eff_addr !== want.eff_addr)
                    report_mismatch("effective address", got.eff_addr, want.eff_addr);
                if (got.store_data !== want.store_data)
                    report_mismatch("store_data", got.store_data, want.store_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_dir_row   dir_rows[$];
        t_instr_txn t;
        t_res       want;
        int         n_dir, n_rand;
        dir_rows = '{
            // MFHI/MFLO straight after reset read zero
            '{'{r_type(5'd0, 5'd0, 5'd3, 5'd0, FN_MFHI), 32'h0, 32'h0, 32'h0}, 1'b1,
              mk_res(1'b1, 5'd3, 32'h0, 1'b0, 1'b0, 32'h4, MK_NONE, 32'h0, 32'h0)},
            '{'{r_type(5'd0, 5'd0, 5'd4, 5'd0, FN_MFLO), 32'hFFFF_FFFC, 32'h0, 32'h0}, 1'b1,
              mk_res(1'b1, 5'd4, 32'h0, 1'b0, 1'b0, 32'h0, MK_NONE, 32'h0, 32'h0)},
            // add wraps, no trap
            '{'{r_type(5'd1, 5'd2, 5'd31, 5'd0, FN_ADD), 32'h100, 32'h7FFF_FFFF, 32'h1}, 1'b1,
              mk_res(1'b1, 5'd31, 32'h8000_0000, 1'b0, 1'b0, 32'h104, MK_NONE, '0, '0)},
            // destination r0 still shows the value
            '{'{r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_SUB), 32'h0, 32'h0, 32'h1}, 1'b1,
              mk_res(1'b0, 5'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h4, MK_NONE, '0, '0)},
            '{'{r_type(5'd0, 5'd2, 5'd5, 5'd31, FN_SRA), 32'h0, 32'h0, 32'h8000_0000}, 1'b0,
              '0},
            '{'{r_type(5'd1, 5'd2, 5'd5, 5'd0, FN_SLLV), 32'h0, 32'hFFFF_FFE1,
                32'h8000_0001}, 1'b0, '0},
            '{'{r_type(5'd1, 5'd2, 5'd5, 5'd0, FN_SRAV), 32'h0, 32'h3F, 32'h8000_0000}, 1'b0,
              '0},
            // divide by zero clears HI and LO
            '{'{r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV), 32'h0, 32'h1234, 32'h0}, 1'b0, '0},
            '{'{r_type(5'd0, 5'd0, 5'd6, 5'd0, FN_MFHI), 32'h0, 32'h0, 32'h0}, 1'b0, '0},
            // most negative / -1
            '{'{r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV), 32'h0, 32'h8000_0000,
                32'hFFFF_FFFF}, 1'b0, '0},
            '{'{r_type(5'd0, 5'd0, 5'd6, 5'd0, FN_MFLO), 32'h0, 32'h0, 32'h0}, 1'b0, '0},
            '{'{r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_MULT), 32'h0, 32'hFFFF_FFFF,
                32'hFFFF_FFFF}, 1'b0, '0},
            '{'{r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_MULTU), 32'h0, 32'hFFFF_FFFF,
                32'hFFFF_FFFF}, 1'b0, '0},
            '{'{r_type(5'd0, 5'd0, 5'd7, 5'd0, FN_MFHI), 32'h0, 32'h0, 32'h0}, 1'b0, '0},
            '{'{r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_DIVU), 32'h0, 32'hFFFF_FFFF, 32'h7}, 1'b0,
              '0},
            '{'{r_type(5'd1, 5'd0, 5'd0, 5'd0, FN_MTHI), 32'h0, 32'hDEAD_BEEF, 32'h0}, 1'b0,
              '0},
            '{'{r_type(5'd1, 5'd0, 5'd0, 5'd0, FN_JR), 32'h40, 32'h1000, 32'h0}, 1'b1,
              mk_res(1'b0, 5'd0, 32'h0, 1'b1, 1'b1, 32'h1000, MK_NONE, '0, '0)},
            // JAL takes its top nibble from pc + 4
            '{'{{OP_JAL, 26'h3FF_FFFF}, 32'hEFFF_FFFC, 32'h0, 32'h0}, 1'b1,
              mk_res(1'b1, 5'd31, 32'hF000_0000, 1'b1, 1'b1, 32'hFFFF_FFFC, MK_NONE, '0, '0)},
            // BLTZAL links even when not taken
            '{'{i_type(OP_REGIMM, 5'd1, RI_BLTZAL, 16'h8000), 32'h100, 32'h1, 32'h0}, 1'b1,
              mk_res(1'b1, 5'd31, 32'h104, 1'b1, 1'b0, 32'h104, MK_NONE, '0, '0)},
            '{'{i_type(OP_BGTZ, 5'd1, 5'd0, 16'h8000), 32'h0002_0000, 32'h1, 32'h0}, 1'b0,
              '0},
            '{'{i_type(OP_LUI, 5'd0, 5'd9, 16'hFFFF), 32'h0, 32'h0, 32'h0}, 1'b1,
              mk_res(1'b1, 5'd9, 32'hFFFF_0000, 1'b0, 1'b0, 32'h4, MK_NONE, '0, '0)},
            '{'{i_type(OP_SLTIUNS, 5'd1, 5'd9, 16'hFFFF), 32'h0, 32'hFFFF_FFFE, 32'h0}, 1'b0,
              '0},
            // loads give result 0; store passes rt
            '{'{i_type(OP_LW, 5'd1, 5'd8, 16'hFFFC), 32'h0, 32'h0, 32'h55}, 1'b1,
              mk_res(1'b1, 5'd8, 32'h0, 1'b0, 1'b0, 32'h4, MK_LW, 32'hFFFF_FFFC, '0)},
            '{'{i_type(OP_SB, 5'd1, 5'd8, 16'h7FFF), 32'h0, 32'hFFFF_FFFF, 32'hA5A5_A5A5},
              1'b1, mk_res(1'b0, 5'd0, 32'h0, 1'b0, 1'b0, 32'h4, MK_SB, 32'h7FFE,
              32'hA5A5_A5A5)},
            // SYSCALL (an unknown function code) acts as a no-op
            '{'{r_type(5'd0, 5'd0, 5'd0, 5'd0, 6'h0C), 32'h0, 32'h1, 32'h2}, 1'b1,
              mk_res(1'b0, 5'd0, 32'h0, 1'b0, 1'b0, 32'h4, MK_NONE, '0, '0)}
        };
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_instr(dir_rows[i].txn);
            if (dir_rows[i].known) begin
                want = exec_queue[$];
                if (want != dir_rows[i].res) begin
                    err_count++;
                    $display("bench model disagrees with table row %0d", i);
                end
            end
        end
        n_dir = dir_rows.size();

        for (n_rand = 0; n_rand < RANDOM_ITEMS; n_rand++) begin
            if (n_rand == RANDOM_ITEMS / 2) begin
                // hold off until everything in flight has drained
                s_axis_tvalid <= 1'b0;
                wait (exec_queue.size() == 0);
                @(negedge i_clk);
            end
            if (n_rand == RANDOM_ITEMS - 60) no_idle = 1'b1;
            t.instr = random_instr();
            t.pc = $urandom_range(0, 1) ? $urandom : (32'($urandom_range(0, 255)) << 2);
            t.rs_val = random_operand();
            t.rt_val = random_operand();
            send_instr(t);
        end
        s_axis_tvalid <= 1'b0;

        wait (exec_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        sink_done = 1'b1;
        $display("%0d directed and %0d random instructions sent, %0d results checked",
                 n_dir, n_rand, rx_count);
        $display("%0d field mismatches", err_count);
        if (err_count == 0 && exec_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- mips32_decode_execute.f -----
src/mde_pkg.sv
src/mde_ctrl.sv
src/mde_dpath.sv
src/mips32_decode_execute.sv
tb/mips32_decode_execute_test.sv
